>>> hdl/ows_pkg.sv
package ows_pkg;

    localparam int unsigned ROM_W = 64;
    localparam int unsigned POS_W = 7;
    localparam int unsigned CRC_W = 8;

    // first position past the last id bit
    localparam logic [POS_W-1:0] END_POSITION = 7'd65;
    // reflected x^8+x^5+x^4+1
    localparam logic [CRC_W-1:0] CRC_POLY = 8'h8C;

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_BIT   = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        ST_BIT   = 3'd0,
        ST_CMD   = 3'd1,
        ST_FOUND = 3'd2,
        ST_NONE  = 3'd3,
        ST_ORDER = 3'd4
    } status_t;

    typedef struct packed {
        logic [ROM_W-1:0] rom_bits;
        logic [POS_W-1:0] last_discrepancy;
        logic             last_device_seen;
        logic [POS_W-1:0] bit_position;
        logic [POS_W-1:0] last_zero_position;
        logic [CRC_W-1:0] crc_value;
        logic             pass_active;
    } search_state_t;

    typedef struct packed {
        status_t          status;
        logic             direction;
        logic [ROM_W-1:0] rom_number;
        logic             last_device;
    } search_result_t;

    localparam search_state_t STATE_RESET = '{
        rom_bits:           '0,
        last_discrepancy:   '0,
        last_device_seen:   1'b0,
        bit_position:       7'd1,
        last_zero_position: '0,
        crc_value:          '0,
        pass_active:        1'b0
    };

endpackage

>>> hdl/ows_decide.sv
module ows_decide (
    input  ows_pkg::search_state_t  state,
    input  logic                    func,
    input  logic                    first,
    input  logic                    presence,
    input  logic                    id_bit,
    input  logic                    compl_bit,
    output ows_pkg::search_state_t  state_next,
    output ows_pkg::search_result_t result
);
    import ows_pkg::*;

    logic [5:0]       idx;
    logic             dir;
    logic             fb;
    logic [ROM_W-1:0] rom_upd;
    logic [CRC_W-1:0] crc_upd;
    logic [POS_W-1:0] pos_upd;
    logic [POS_W-1:0] zero_upd;
    logic             ldev_start;

    // direction choice, rom, crc and position for a bit pair
    always_comb
    begin
        idx      = 6'(state.bit_position - 7'd1);
        zero_upd = state.last_zero_position;
        if (id_bit != compl_bit)
        begin
            dir = id_bit;
        end
        else
        begin
            if (state.bit_position < state.last_discrepancy)
                dir = state.rom_bits[idx];
            else
                dir = (state.bit_position == state.last_discrepancy);
            if (!dir)
                zero_upd = state.bit_position;
        end
        rom_upd      = state.rom_bits;
        rom_upd[idx] = dir;
        fb           = state.crc_value[0] ^ dir;
        crc_upd      = (state.crc_value >> 1) ^ (fb ? CRC_POLY : '0);
        pos_upd      = state.bit_position + 7'd1;
    end

    always_comb
    begin
        state_next         = state;
        result.status      = ST_NONE;
        result.direction   = 1'b0;
        result.rom_number  = '0;
        result.last_device = 1'b0;
        ldev_start         = state.last_device_seen & ~first;

        if (func == FUNC_START)
        begin
            state_next.bit_position       = 7'd1;
            state_next.last_zero_position = '0;
            state_next.crc_value          = '0;
            if (first)
            begin
                state_next.last_discrepancy = '0;
                state_next.last_device_seen = 1'b0;
            end
            if (ldev_start || !presence)
            begin
                state_next.last_discrepancy = '0;
                state_next.last_device_seen = 1'b0;
                state_next.pass_active      = 1'b0;
                result.status               = ST_NONE;
            end
            else
            begin
                state_next.pass_active = 1'b1;
                result.status          = ST_CMD;
            end
        end
        else if (!state.pass_active)
        begin
            result.status = ST_ORDER;
        end
        else if (id_bit && compl_bit)
        begin
            // nobody answered the pair
            state_next.last_discrepancy = '0;
            state_next.last_device_seen = 1'b0;
            state_next.pass_active      = 1'b0;
            result.status               = ST_NONE;
        end
        else
        begin
            state_next.rom_bits           = rom_upd;
            state_next.crc_value          = crc_upd;
            state_next.bit_position       = pos_upd;
            state_next.last_zero_position = zero_upd;
            result.direction              = dir;
            if (pos_upd < END_POSITION)
            begin
                result.status = ST_BIT;
            end
            else
            begin
                state_next.pass_active = 1'b0;
                if (crc_upd == '0 && rom_upd[7:0] != '0)
                begin
                    state_next.last_discrepancy = zero_upd;
                    state_next.last_device_seen = (zero_upd == '0);
                    result.status               = ST_FOUND;
                    result.rom_number           = rom_upd;
                    result.last_device          = (zero_upd == '0);
                end
                else
                begin
                    state_next.last_discrepancy = '0;
                    state_next.last_device_seen = 1'b0;
                    result.status               = ST_NONE;
                end
            end
        end
    end

endmodule

>>> hdl/one_wire_rom_search.sv
// one-wire rom search decision engine, one search pass per device found
//
// request channel (req_valid / req_stall): func selects a start request
// (first, presence) or one id / complement bit pair read off the bus
// result channel (res_valid / res_stall): status, direction, rom_number and
// last_device, exactly one result per request
// the decision logic sits between the search state and the result register,
// so a result shows the cycle after its request is taken
// throughput: one request per cycle; a new request is taken whenever the
// result register is empty or its content is taken in the same cycle
// stall: while res_stall holds a waiting result, req_stall is raised and the
// result and search state hold still
// reset: search state goes to its first-search values (bit position one,
// no pass open), result register empties
module one_wire_rom_search (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        func,
    input  logic        first,
    input  logic        presence,
    input  logic        id_bit,
    input  logic        compl_bit,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [2:0]  status,
    output logic        direction,
    output logic [63:0] rom_number,
    output logic        last_device
);
    import ows_pkg::*;

    search_state_t  state_reg;
    search_state_t  state_next;
    search_result_t result_next;
    search_result_t result_reg;
    logic           res_valid_reg;
    logic           res_valid_next;
    logic           accept;

    // input stalls while the result register holds a result not taken this cycle
    assign req_stall = res_valid_reg & res_stall;
    assign accept    = req_valid & ~req_stall;

    ows_decide u_decide (
        .state      (state_reg),
        .func       (func),
        .first      (first),
        .presence   (presence),
        .id_bit     (id_bit),
        .compl_bit  (compl_bit),
        .state_next (state_next),
        .result     (result_next)
    );

    always_comb
    begin
        if (accept)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    // search state only moves on an accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (accept)
                state_reg <= state_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign res_valid   = res_valid_reg;
    assign status      = result_reg.status;
    assign direction   = result_reg.direction;
    assign rom_number  = result_reg.rom_number;
    assign last_device = result_reg.last_device;

    // an open pass always points at one of the 64 id bits
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pass_active |-> (state_reg.bit_position >= 7'd1 &&
                                   state_reg.bit_position <= 7'd64))
        else $error("bit position out of range during a pass");

    // a start request rewinds position and crc
    a_start_rewind: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func == FUNC_START) |=>
            (state_reg.bit_position == 7'd1 && state_reg.crc_value == '0))
        else $error("start request did not rewind the pass");

    // a found device reports the same last-device flag the state keeps
    a_found_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (result_reg.status != ST_FOUND ||
                    result_reg.last_device == state_reg.last_device_seen))
        else $error("last device flag disagrees with search state");

    // rom number only leaves with a found device
    a_rom_only_found: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && result_reg.status != ST_FOUND) |-> result_reg.rom_number == '0)
        else $error("rom number driven without a found device");

endmodule

>>> tb/sv/one_wire_rom_search_tb.sv
module one_wire_rom_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ows_pkg::*;

    // run shape
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned TARGET_REQUESTS = 1300;
    localparam int unsigned IDLE_PCT        = 14;
    localparam int unsigned HOLD_AT         = 500;
    localparam int unsigned HOLD_CYCLES     = 150;
    localparam int unsigned QUIET_FROM      = 800;
    localparam int unsigned QUIET_TO        = 1000;
    localparam int unsigned TAIL_CYCLES     = 10;
    localparam int unsigned MAX_DEVICES     = 8;
    localparam int unsigned REPORT_CAP      = 100;

    // kinds of damage done to a pass on the bus
    localparam int unsigned BREAK_FLIP_ID  = 0;
    localparam int unsigned BREAK_FLIP_CMP = 1;
    localparam int unsigned BREAK_BOTH_ONE = 2;
    localparam int unsigned BREAK_RESTART  = 3;

    // search state straight out of reset
    localparam search_state_t SEARCH_RESET = '{
        rom_bits:           '0,
        last_discrepancy:   '0,
        last_device_seen:   1'b0,
        bit_position:       7'd1,
        last_zero_position: '0,
        crc_value:          '0,
        pass_active:        1'b0
    };

    // one request as offered on the bus, plus a flag that holds it back
    // until every earlier result has come out
    typedef struct packed {
        func_t func;
        logic  first;
        logic  presence;
        logic  id_bit;
        logic  compl_bit;
        logic  hold_until_drained;
    } bus_request_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic        func = 1'b0;
    logic        first = 1'b0;
    logic        presence = 1'b0;
    logic        id_bit = 1'b0;
    logic        compl_bit = 1'b0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [2:0]  status;
    logic        direction;
    logic [63:0] rom_number;
    logic        last_device;

    // search state used while planning the stimulus, and the one tracking
    // the block as requests are actually taken
    search_state_t  plan_state;
    search_state_t  track_state;
    bus_request_t   bus_requests[$];
    search_result_t due_results[$];
    logic [63:0]    bus_roms[$];
    bus_request_t   on_bus;
    search_result_t step_result;
    search_result_t want;
    logic           pause_next = 1'b0;
    int unsigned    taken = 0;
    int unsigned    cycles = 0;
    int unsigned    hold_left = 0;
    logic           hold_done = 1'b0;
    int unsigned    errors = 0;
    logic           quiet;

    // a stretch of the run where neither side idles
    assign quiet = (taken >= QUIET_FROM) && (taken < QUIET_TO);

    one_wire_rom_search i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .func        (func),
        .first       (first),
        .presence    (presence),
        .id_bit      (id_bit),
        .compl_bit   (compl_bit),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .status      (status),
        .direction   (direction),
        .rom_number  (rom_number),
        .last_device (last_device)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one step of the search engine: applies a request to the state and
    // gives the single result it causes
    task automatic search_response(inout search_state_t s, input bus_request_t r,
                                   output search_result_t res);
        logic       dir;
        logic       fb;
        logic [5:0] idx;
        res = '0;
        res.status = ST_ORDER;
        if (r.func == FUNC_START)
        begin
            if (r.first)
            begin
                s.last_discrepancy = '0;
                s.last_device_seen = 1'b0;
            end
            s.bit_position = 7'd1;
            s.last_zero_position = '0;
            s.crc_value = '0;
            s.pass_active = 1'b0;
            if (s.last_device_seen || !r.presence)
            begin
                // nobody answered, or the previous pass found the last one
                s.last_discrepancy = '0;
                s.last_device_seen = 1'b0;
                res.status = ST_NONE;
            end
            else
            begin
                s.pass_active = 1'b1;
                res.status = ST_CMD;
            end
        end
        else if (!s.pass_active)
        begin
            res.status = ST_ORDER;
        end
        else if (r.id_bit && r.compl_bit)
        begin
            // no device left on the bus: the pass dies, rom bits kept
            s.last_discrepancy = '0;
            s.last_device_seen = 1'b0;
            s.pass_active = 1'b0;
            res.status = ST_NONE;
        end
        else
        begin
            idx = 6'(s.bit_position - 7'd1);
            if (r.id_bit != r.compl_bit)
            begin
                dir = r.id_bit;
            end
            else
            begin
                // discrepancy: repeat the old path, turn at the last
                // discrepancy, take zero beyond it
                if (s.bit_position < s.last_discrepancy)
                    dir = s.rom_bits[idx];
                else
                    dir = (s.bit_position == s.last_discrepancy);
                if (!dir)
                    s.last_zero_position = s.bit_position;
            end
            s.rom_bits[idx] = dir;
            fb = s.crc_value[0] ^ dir;
            s.crc_value = s.crc_value >> 1;
            if (fb)
                s.crc_value ^= CRC_POLY;
            s.bit_position = s.bit_position + 7'd1;
            res.direction = dir;
            if (s.bit_position < END_POSITION)
            begin
                res.status = ST_BIT;
            end
            else
            begin
                s.pass_active = 1'b0;
                if (s.crc_value == '0 && s.rom_bits[7:0] != 8'h00)
                begin
                    s.last_discrepancy = s.last_zero_position;
                    s.last_device_seen = (s.last_zero_position == '0);
                    res.status = ST_FOUND;
                    res.rom_number = s.rom_bits;
                    res.last_device = s.last_device_seen;
                end
                else
                begin
                    // bad crc or zero family: direction of the last bit stays
                    s.last_discrepancy = '0;
                    s.last_device_seen = 1'b0;
                    res.status = ST_NONE;
                end
            end
        end
    endtask

    // queue one request for the driver and tell the planner what it causes
    task automatic add_request(input func_t f, input logic fst, input logic prs,
                               input logic idb, input logic cmpb,
                               output search_result_t res);
        bus_request_t r;
        r.func = f;
        r.first = fst;
        r.presence = prs;
        r.id_bit = idb;
        r.compl_bit = cmpb;
        r.hold_until_drained = pause_next;
        pause_next = 1'b0;
        search_response(plan_state, r, res);
        bus_requests.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        // keep the log short on a badly broken block
        if (errors < REPORT_CAP)
            $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, exp_val);
        errors++;
    endtask

    // request driver: predicts on each accepted request, then offers the next
    // one or idles; a stalled request is held as it stands
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                search_response(track_state, on_bus, step_result);
                due_results.push_back(step_result);
                taken <= taken + 1;
            end
            if (!req_valid || !req_stall)
            begin
                if (bus_requests.size() != 0
                    && !(bus_requests[0].hold_until_drained && due_results.size() != 0)
                    && (quiet || $urandom_range(99) >= IDLE_PCT))
                begin
                    on_bus = bus_requests.pop_front();
                    req_valid  <= 1'b1;
                    func       <= on_bus.func;
                    first      <= on_bus.first;
                    presence   <= on_bus.presence;
                    id_bit     <= on_bus.id_bit;
                    compl_bit  <= on_bus.compl_bit;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: every result taken is matched against the oldest
    // outstanding prediction
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (due_results.size() == 0)
            begin
                report_mismatch("result with no request outstanding", 64'(status), 64'd0);
            end
            else
            begin
                want = due_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 64'(status), 64'(want.status));
                if (direction !== want.direction)
                    report_mismatch("direction", 64'(direction), 64'(want.direction));
                if (rom_number !== want.rom_number)
                    report_mismatch("rom_number", rom_number, want.rom_number);
                if (last_device !== want.last_device)
                    report_mismatch("last_device", 64'(last_device), 64'(want.last_device));
            end
        end
    end

    // receiver back-pressure: random stalls, one long hold-off once enough
    // requests have gone in so the block fills and stalls its input
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            res_stall <= 1'b1;
        end
        else if (!hold_done && taken >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("one_wire_rom_search: mismatch");
            $finish;
        end
    end

    // stimulus planning, reset, and the end of the run
    initial
    begin : stimulus
        search_result_t res;
        logic [55:0]    body;
        logic [55:0]    dbody;
        logic [7:0]     crc;
        logic [63:0]    rom;
        logic           idb;
        logic           cmpb;
        logic           fb;
        logic           fresh;
        logic           prs;
        bit             alive [MAX_DEVICES];
        int             ndev;
        int             passes;
        int             brk;
        int             kind;
        int             mode;
        int             b;
        int             d;
        int             i;

        plan_state = SEARCH_RESET;
        track_state = SEARCH_RESET;

        // directed: bit pairs before any pass
        add_request(FUNC_BIT, 1'b0, 1'b0, 1'b0, 1'b1, res);
        add_request(FUNC_BIT, 1'b1, 1'b1, 1'b1, 1'b1, res);
        // start with no presence pulse
        add_request(FUNC_START, 1'b1, 1'b0, 1'b1, 1'b0, res);
        // start, then both bits one kills the pass
        add_request(FUNC_START, 1'b0, 1'b1, 1'b0, 1'b0, res);
        add_request(FUNC_BIT, 1'b0, 1'b0, 1'b1, 1'b1, res);
        add_request(FUNC_BIT, 1'b0, 1'b0, 1'b0, 1'b1, res);
        // a few plain bits: zero-one, one-zero and a discrepancy
        add_request(FUNC_START, 1'b1, 1'b1, 1'b1, 1'b1, res);
        add_request(FUNC_BIT, 1'b1, 1'b0, 1'b0, 1'b1, res);
        add_request(FUNC_BIT, 1'b0, 1'b1, 1'b1, 1'b0, res);
        add_request(FUNC_BIT, 1'b1, 1'b1, 1'b0, 1'b0, res);
        // start in the middle of a pass drops it
        add_request(FUNC_START, 1'b0, 1'b1, 1'b0, 1'b1, res);
        add_request(FUNC_BIT, 1'b0, 1'b0, 1'b0, 1'b0, res);
        add_request(FUNC_BIT, 1'b1, 1'b1, 1'b1, 1'b0, res);
        // sender waits for every result before going on
        pause_next = 1'b1;
        add_request(FUNC_START, 1'b1, 1'b0, 1'b0, 1'b0, res);

        // random part: whole searches over a simulated bus of devices, with
        // stray requests in between and the odd pass damaged on the way
        while (bus_requests.size() < TARGET_REQUESTS)
        begin
            if ($urandom_range(99) < 30)
            begin
                repeat ($urandom_range(5, 1))
                    add_request(func_t'($urandom_range(1)), 1'($urandom), 1'($urandom),
                                1'($urandom), 1'($urandom), res);
            end
            if ($urandom_range(9) == 0)
                pause_next = 1'b1;

            // devices mostly share a common body so the search must branch
            if ($urandom_range(19) == 0)
                ndev = 0;
            else if ($urandom_range(9) == 0)
                ndev = MAX_DEVICES;
            else
                ndev = $urandom_range(4, 1);
            bus_roms.delete();
            body = 56'({$urandom, $urandom});
            for (d = 0; d < ndev; d++)
            begin
                mode = $urandom_range(19);
                if (mode == 0)
                begin
                    dbody = '1;
                end
                else if (mode == 1)
                begin
                    dbody = 56'({$urandom, $urandom});
                end
                else
                begin
                    dbody = body;
                    repeat ($urandom_range(4, 1))
                    begin
                        i = $urandom_range(55);
                        dbody[i] = ~dbody[i];
                    end
                end
                if (dbody[7:0] == 8'h00)
                    dbody[0] = 1'b1;
                // zero family code
                if (mode == 2)
                    dbody[7:0] = 8'h00;
                crc = 8'h00;
                for (i = 0; i < 56; i++)
                begin
                    fb = crc[0] ^ dbody[i];
                    crc = crc >> 1;
                    if (fb)
                        crc ^= CRC_POLY;
                end
                rom = {crc, dbody};
                // corrupt crc byte
                if (mode == 3)
                    rom[63:56] ^= 8'($urandom_range(255, 1));
                bus_roms.push_back(rom);
            end

            passes = 0;
            do
            begin
                fresh = (passes == 0) ? 1'b1 : ($urandom_range(19) == 0);
                prs = (ndev != 0) ? ($urandom_range(29) != 0) : 1'($urandom);
                add_request(FUNC_START, fresh, prs, 1'($urandom), 1'($urandom), res);
                passes++;
                if (res.status == ST_CMD)
                begin
                    for (d = 0; d < MAX_DEVICES; d++)
                        alive[d] = (d < ndev);
                    brk = ($urandom_range(99) < 12) ? $urandom_range(63) : -1;
                    kind = $urandom_range(BREAK_RESTART);
                    for (b = 0; b < 64; b++)
                    begin
                        // wired-and of every device still in: bit then complement
                        idb = 1'b1;
                        cmpb = 1'b1;
                        for (d = 0; d < ndev; d++)
                        begin
                            if (alive[d])
                            begin
                                idb &= bus_roms[d][b];
                                cmpb &= ~bus_roms[d][b];
                            end
                        end
                        if (b == brk && kind == BREAK_RESTART)
                        begin
                            add_request(FUNC_START, 1'($urandom), 1'b1,
                                        1'($urandom), 1'($urandom), res);
                            break;
                        end
                        if (b == brk && kind == BREAK_FLIP_ID)
                            idb = ~idb;
                        if (b == brk && kind == BREAK_FLIP_CMP)
                            cmpb = ~cmpb;
                        if (b == brk && kind == BREAK_BOTH_ONE)
                        begin
                            idb = 1'b1;
                            cmpb = 1'b1;
                        end
                        add_request(FUNC_BIT, 1'($urandom), 1'($urandom), idb, cmpb, res);
                        if (res.status != ST_BIT)
                            break;
                        // devices whose bit differs from the written one drop out
                        for (d = 0; d < ndev; d++)
                        begin
                            if (bus_roms[d][b] != res.direction)
                                alive[d] = 1'b0;
                        end
                    end
                end
            end
            while (!(res.status == ST_FOUND && res.last_device) && passes < ndev + 2);

            // one more start once the last device is out
            if (res.status == ST_FOUND && res.last_device)
                add_request(FUNC_START, 1'b0, 1'b1, 1'($urandom), 1'($urandom), res);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // drain: everything offered, taken and answered
        do
            @(posedge clk);
        while (bus_requests.size() != 0 || req_valid || due_results.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("one_wire_rom_search: match");
        else
            $display("one_wire_rom_search: mismatch");
        $finish;
    end

endmodule

>>> one_wire_rom_search.f
hdl/ows_pkg.sv
hdl/ows_decide.sv
hdl/one_wire_rom_search.sv
tb/sv/one_wire_rom_search_tb.sv
